/* sv/fpba_pkg.sv */
package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int SLOT_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS   = 5;
  localparam int CFG_BITS   = 5;
  localparam int CFG_IDX_BITS = 1;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // placement policies; the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic rd_en;
    logic scan_inc;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
    logic none_in_use;
    logic out_busy;
  } dp_stat_t;

endpackage

/* sv/fpba_ctrl.sv */
module fpba_ctrl import fpba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     operation_i,
  input  dp_stat_t stat_i,
  output logic     in_stall_o,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d = stat_i.none_in_use ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.last) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      // let the last entry's compare land
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/fpba_datapath.sv */
module fpba_datapath import fpba_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 cfg_wr_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]  cfg_data_i,
  input  logic [SLOT_BITS-1:0] block_slot_i,
  input  logic [SIZE_BITS-1:0] amount_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 granted_o,
  output logic [SLOT_BITS-1:0] chosen_slot_o,
  output logic [SIZE_BITS-1:0] left_over_o
);

  logic [1:0]          policy_q;
  logic [CNT_BITS-1:0] blocks_q;

  logic [SIZE_BITS-1:0] mem_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_q;

  logic [SLOT_BITS-1:0] idx_q;
  logic [SIZE_BITS-1:0] amount_q;
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_ok_q;
  logic                 cmp_en_q;
  logic [SLOT_BITS-1:0] cmp_idx_q;
  logic                 found_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [SLOT_BITS-1:0] best_idx_q;

  logic                 out_valid_q;
  logic                 granted_q;
  logic [SLOT_BITS-1:0] slot_q;
  logic [SIZE_BITS-1:0] left_q;

  logic [CNT_BITS-1:0]  count;
  logic [SIZE_BITS-1:0] entry_size;
  logic [SIZE_BITS-1:0] remain;
  logic                 fits;
  logic                 take;
  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      blocks_q <= CNT_BITS'(16);
    end else if (cfg_wr_i) begin
      if (cfg_index_i == CFG_POLICY) begin
        policy_q <= cfg_data_i[1:0];
      end else begin
        blocks_q <= cfg_data_i[CNT_BITS-1:0];
      end
    end
  end

  // saturate the scan length to the table depth
  assign count = (blocks_q > CNT_BITS'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS) : blocks_q;

  assign stat_o.none_in_use = (count == '0);
  assign stat_o.last        = (CNT_BITS'(idx_q) == count - CNT_BITS'(1));
  assign stat_o.out_busy    = out_valid_q && out_stall_i;

  // single write port: loads and the final update never meet
  assign remain  = best_q - amount_q;
  assign wr_en   = cmd_i.load_wr || (cmd_i.finish && found_q);
  assign wr_addr = cmd_i.load_wr ? block_slot_i : best_idx_q;
  assign wr_data = cmd_i.load_wr ? amount_i : remain;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      cmp_en_q <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_ok_q <= valid_q[idx_q];
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_inc) begin
        idx_q <= idx_q + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (cmd_i.start) begin
      amount_q <= amount_i;
    end
  end

  // an entry never written reads as zero
  assign entry_size = rd_ok_q ? rd_data_q : '0;
  assign fits = (entry_size >= amount_q);

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (policy_q == POL_BEST) begin
        take = (entry_size <= best_q);
      end else if (policy_q == POL_WORST) begin
        take = (entry_size > best_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (cmp_en_q && take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_q && take) begin
      best_q     <= entry_size;
      best_idx_q <= cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      granted_q <= found_q;
      slot_q    <= found_q ? best_idx_q : '0;
      left_q    <= found_q ? remain : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign chosen_slot_o = slot_q;
  assign left_over_o   = left_q;

endmodule

/* sv/fit_policy_block_allocator.sv */
// Fit-policy block allocator. Holds the free size of up to NUM_BLOCKS blocks
// in a small table (all zero after reset). A load word (operation 0) writes
// one entry and returns nothing. An allocate word (operation 1) scans
// entries 0 to min(blocks_in_use, NUM_BLOCKS)-1 one per cycle through the
// table's single read port, picks an entry by the policy register (first,
// best or worst fit), subtracts the request from it and returns one result
// word. After the scan it passes a drain state and a finish state before the
// result register is loaded; a result word still held by out_stall_i delays
// the finish. The scan length is set by the one-entry-per-cycle table read.
// Configuration writes are always ready and must be made while the block is
// idle.
module fit_policy_block_allocator import fpba_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [SLOT_BITS-1:0]    block_slot_i,
  input  logic [SIZE_BITS-1:0]    amount_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    granted_o,
  output logic [SLOT_BITS-1:0]    chosen_slot_o,
  output logic [SIZE_BITS-1:0]    left_over_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  fpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  fpba_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_wr_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .block_slot_i  (block_slot_i),
    .amount_i      (amount_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .granted_o     (granted_o),
    .chosen_slot_o (chosen_slot_o),
    .left_over_o   (left_over_o)
  );

endmodule

/* sv/fpba_checker.sv */
module fpba_checker import fpba_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input logic [CFG_BITS-1:0]     cfg_data_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    operation_i,
  input logic [SLOT_BITS-1:0]    block_slot_i,
  input logic [SIZE_BITS-1:0]    amount_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    granted_o,
  input logic [SLOT_BITS-1:0]    chosen_slot_o,
  input logic [SIZE_BITS-1:0]    left_over_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_o)
      && $stable(chosen_slot_o) && $stable(left_over_o))
    else $error("result word changed under stall");

  // a refused allocation reports zeros
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> chosen_slot_o == '0 && left_over_o == '0)
    else $error("refused allocation with non-zero fields");

  // a load leaves the input ready for the next word
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OP_LOAD |=> !in_stall_o)
    else $error("load word kept the input stalled");

  // an allocate occupies the block
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == OP_ALLOC |=> in_stall_o)
    else $error("input accepted during an allocate");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

/* tb/testbench.sv */
module testbench;
  import fpba_pkg::*;

  localparam int SETTLE_CYCLES  = NUM_BLOCKS + 8;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 95;
  // spare policy code, must behave as first fit
  localparam logic [1:0] POL_SPARE = 2'd3;

  typedef struct packed {
    logic                 granted;
    logic [SLOT_BITS-1:0] slot;
    logic [SIZE_BITS-1:0] left;
  } grant_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_ALLOC,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [SLOT_BITS-1:0] slot;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [SIZE_BITS-1:0] value;
    logic                 typed;
    grant_t               want;
  } script_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    operation_i = OP_LOAD;
  logic [SLOT_BITS-1:0]    block_slot_i = '0;
  logic [SIZE_BITS-1:0]    amount_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    granted_o;
  logic [SLOT_BITS-1:0]    chosen_slot_o;
  logic [SIZE_BITS-1:0]    left_over_o;

  // model of the allocator
  logic [SIZE_BITS-1:0] free_size [NUM_BLOCKS];
  logic [1:0]           fit_policy;
  logic [CNT_BITS-1:0]  scan_count;

  grant_t      pending_grants[$];
  script_row_t script[$];
  int          fault_count = 0;
  int          quiet_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;

  fit_policy_block_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .block_slot_i  (block_slot_i),
    .amount_i      (amount_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .granted_o     (granted_o),
    .chosen_slot_o (chosen_slot_o),
    .left_over_o   (left_over_o)
  );

  always #10 clk_i = ~clk_i;

  // pick an entry by the current policy and take the request from it
  function automatic grant_t place_request(logic [SIZE_BITS-1:0] req);
    grant_t res;
    int     span;
    int     pick;
    res = '0;
    pick = -1;
    span = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
    for (int i = 0; i < span; i++) begin
      if (free_size[i] >= req) begin
        if (pick < 0) begin
          pick = i;
        end else if (fit_policy == POL_BEST && free_size[i] <= free_size[pick]) begin
          pick = i;
        end else if (fit_policy == POL_WORST && free_size[i] > free_size[pick]) begin
          pick = i;
        end
      end
    end
    if (pick >= 0) begin
      free_size[pick] = free_size[pick] - req;
      res.granted = 1'b1;
      res.slot = pick[SLOT_BITS-1:0];
      res.left = free_size[pick];
    end
    return res;
  endfunction

  function automatic script_row_t load_row(int slot, int amount);
    script_row_t r;
    r = '0;
    r.kind = ROW_LOAD;
    r.slot = slot[SLOT_BITS-1:0];
    r.value = amount[SIZE_BITS-1:0];
    return r;
  endfunction

  function automatic script_row_t alloc_row(int amount, bit typed, bit g, int s, int l);
    script_row_t r;
    r = '0;
    r.kind = ROW_ALLOC;
    r.value = amount[SIZE_BITS-1:0];
    r.typed = typed;
    r.want.granted = g;
    r.want.slot = s[SLOT_BITS-1:0];
    r.want.left = l[SIZE_BITS-1:0];
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CFG_BITS-1:0] data);
    script_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = SIZE_BITS'(data);
    return r;
  endfunction

  task automatic flag_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // entered and left at a falling edge; valid stays high for a back-to-back word
  task automatic send_word(logic op, logic [SLOT_BITS-1:0] slot,
                           logic [SIZE_BITS-1:0] amount, bit typed, grant_t want);
    int     gap;
    grant_t got;
    gap = tx_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    block_slot_i = slot;
    amount_i = amount;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (op == OP_LOAD) begin
      free_size[slot] = amount;
    end else begin
      got = place_request(amount);
      pending_grants.push_back(typed ? want : got);
    end
    @(negedge clk_i);
  endtask

  // drop valid, wait for every result, then let a late scan finish
  task automatic quiesce();
    in_valid_i = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == CFG_POLICY) fit_policy = data[1:0];
    else scan_count = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_grants.size() == 0) begin
        flag_fault($sformatf("unexpected result: granted %0d slot %0d left %0d",
                             granted_o, chosen_slot_o, left_over_o));
      end else begin
        want = pending_grants.pop_front();
        if (granted_o !== want.granted || chosen_slot_o !== want.slot ||
            left_over_o !== want.left) begin
          flag_fault($sformatf({"mismatch: expected granted %0d slot %0d left %0d,",
                                " got granted %0d slot %0d left %0d"},
                               want.granted, want.slot, want.left,
                               granted_o, chosen_slot_o, left_over_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // result side: hold stall for a random spell, then take one word
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = rx_gaps_on ? $urandom_range(0, 17) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      out_stall_i = (hold != 0);
      repeat (hold) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin
    script_row_t          row;
    logic [1:0]           pol;
    logic [CNT_BITS-1:0]  blocks;
    logic [SIZE_BITS-1:0] amt;
    logic [SLOT_BITS-1:0] slot;
    logic                 op;
    int                   span;
    int                   roll;
    int                   mode;

    fit_policy = POL_FIRST;
    scan_count = CNT_BITS'(NUM_BLOCKS);
    for (int i = 0; i < NUM_BLOCKS; i++) free_size[i] = '0;

    // empty table after reset, then extremes and each policy with its tie rule
    script.push_back(alloc_row(0, 1, 1, 0, 0));
    script.push_back(alloc_row(1, 1, 0, 0, 0));
    script.push_back(alloc_row(16'hFFFF, 1, 0, 0, 0));
    script.push_back(load_row(15, 16'hFFFF));
    script.push_back(alloc_row(16'hFFFF, 1, 1, 15, 0));
    script.push_back(load_row(0, 10));
    script.push_back(load_row(3, 100));
    script.push_back(load_row(7, 40));
    script.push_back(load_row(9, 40));
    script.push_back(load_row(12, 200));
    script.push_back(alloc_row(30, 0, 0, 0, 0));
    script.push_back(cfg_row(CFG_POLICY, CFG_BITS'(POL_BEST)));
    script.push_back(alloc_row(40, 0, 0, 0, 0));
    script.push_back(cfg_row(CFG_POLICY, CFG_BITS'(POL_WORST)));
    script.push_back(load_row(5, 200));
    script.push_back(alloc_row(50, 0, 0, 0, 0));
    script.push_back(cfg_row(CFG_POLICY, {3'b111, POL_SPARE}));
    script.push_back(alloc_row(5, 0, 0, 0, 0));
    script.push_back(cfg_row(CFG_BLOCKS, 5'd0));
    script.push_back(alloc_row(0, 1, 0, 0, 0));
    script.push_back(cfg_row(CFG_BLOCKS, 5'd31));
    script.push_back(alloc_row(150, 0, 0, 0, 0));
    script.push_back(cfg_row(CFG_POLICY, {3'b111, POL_FIRST}));
    script.push_back(cfg_row(CFG_BLOCKS, 5'd1));
    script.push_back(alloc_row(5, 0, 0, 0, 0));
    script.push_back(alloc_row(1, 1, 0, 0, 0));
    script.push_back(cfg_row(CFG_POLICY, CFG_BITS'(POL_BEST)));
    script.push_back(cfg_row(CFG_BLOCKS, 5'd17));
    script.push_back(alloc_row(0, 0, 0, 0, 0));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < script.size(); n++) begin
      row = script[n];
      if (row.kind == ROW_CFG) begin
        quiesce();
        write_reg(row.reg_idx, row.value[CFG_BITS-1:0]);
      end else begin
        op = (row.kind == ROW_LOAD) ? OP_LOAD : OP_ALLOC;
        send_word(op, row.slot, row.value, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph % 4)
        0:       pol = POL_FIRST;
        1:       pol = POL_BEST;
        2:       pol = POL_WORST;
        default: pol = POL_SPARE;
      endcase
      case (ph)
        0:       blocks = CNT_BITS'(NUM_BLOCKS);
        1:       blocks = 5'd1;
        2:       blocks = 5'd31;
        default: blocks = CNT_BITS'($urandom_range(2, NUM_BLOCKS));
      endcase
      write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), pol});
      write_reg(CFG_BLOCKS, blocks);
      tx_gaps_on = (ph != 4) && (ph % 3 != 2);
      rx_gaps_on = (ph != 4) && (ph % 3 != 1);
      span = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);

      for (int k = 0; k < PHASE_WORDS; k++) begin
        // long receiver hold-off while the sender keeps offering words
        if (ph == 5 && k == 20) long_hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        slot = SLOT_BITS'($urandom_range(0, NUM_BLOCKS - 1));
        if (roll < 40) begin
          op = OP_LOAD;
          mode = $urandom_range(0, 3);
          case (mode)
            0:       amt = SIZE_BITS'($urandom);
            1:       amt = SIZE_BITS'($urandom_range(0, 255));
            2:       amt = free_size[$urandom_range(0, NUM_BLOCKS - 1)];
            default: amt = $urandom_range(0, 1) ? '1 : '0;
          endcase
        end else begin
          op = OP_ALLOC;
          mode = $urandom_range(0, 9);
          if (mode <= 5) begin
            amt = SIZE_BITS'($urandom_range(0, free_size[$urandom_range(0, span - 1)]));
          end else if (mode == 6) begin
            amt = '0;
          end else if (mode == 7) begin
            amt = '1;
          end else begin
            amt = SIZE_BITS'($urandom);
          end
        end
        send_word(op, slot, amt, 1'b0, '0);
      end
    end

    quiesce();
    if (fault_count == 0 && pending_grants.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/fpba_pkg.sv
sv/fpba_ctrl.sv
sv/fpba_datapath.sv
sv/fit_policy_block_allocator.sv
sv/fpba_checker.sv
tb/testbench.sv
